// ----- hdl/ray_supercover_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// Ray supercover rasterizer assertion macros
// Shared concurrent check wrappers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_SUPERCOVER_RASTERIZER_MACROS_SVH
`define RAY_SUPERCOVER_RASTERIZER_MACROS_SVH

// invariant that holds on every cycle out of reset
`define RSR_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence that must hold in the cycle after a trigger
`define RSR_CHECK_NEXT(name, trig, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- hdl/rsr_pkg.sv -----
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared constants, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package rsr_pkg;

   localparam int COORD_BITS  = 22;
   localparam int SCALE_BITS  = 11;
   localparam int MAX_CELLS   = 64;
   localparam int CNT_BITS    = $clog2(MAX_CELLS + 1);
   localparam int MUL_B_BITS  = SCALE_BITS + 1;
   localparam int PROD_BITS   = COORD_BITS + MUL_B_BITS;
   localparam int ACC_BITS    = PROD_BITS + 4;
   localparam int DIV_CNT_BITS = $clog2(COORD_BITS);
   localparam int REQ_BITS    = 4 * COORD_BITS;
   localparam int REQ_BYTES   = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS    = 2 * COORD_BITS;
   localparam int RSP_BYTES   = (RSP_BITS + 7) / 8;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1000);

   // multiply schedule
   localparam logic [2:0] MUL_DEN  = 3'd0;
   localparam logic [2:0] MUL_T1   = 3'd1;
   localparam logic [2:0] MUL_T2   = 3'd2;
   localparam logic [2:0] MUL_STEP = 3'd3;
   localparam logic [2:0] MUL_T3   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_SETUP, ST_VERT, ST_MUL, ST_INIT,
      ST_EMIT, ST_INNER, ST_STEP, ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic div_run;
      logic setup;
      logic emit_v;
      logic mul_run;
      logic walk_init;
      logic emit_e;
      logic emit_i;
      logic step;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic vertical;
      logic cy_at_hi;
      logic acc_gt;
      logic tail;
      logic full;
      logic can_emit;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/ray_supercover_rasterizer.sv -----
// ----------------------------------------------------------------------------
// ray_supercover_rasterizer
// Lists every full pixel touched by one subpixel-scaled ray.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction carries a ray (begin_x, begin_y, end_x,
//   end_y), 22 bits each. req_tready is high only while the block is idle;
//   one ray is handled at a time.
//   rsp channel: one transaction per touched pixel (cell_x, cell_y) in walk
//   order; tlast marks the final cell of the ray, tuser flags that the run
//   was cut at 64 cells.
//   csr port: csr_we writes the pixel scale (0 acts as 1); write only idle.
// Timing:
//   Bit-serial division (four lanes), a setup state, then for slanted rays
//   the products on the shared multiplier and an init state. Inside a pixel
//   column the walk emits one cell per cycle while the output is not held;
//   each column step adds an exit check and an x step. Vertical rays emit
//   one cell a cycle while the output is not held. A finish state loads the
//   last cell once the output is free.
// Reset: synchronous, returns to idle, drops rsp_tvalid, scale back to 1000.
// Stall: a held result blocks the walk; the one-cell pending stage keeps
//   the next cell so tlast can be set once the ray is known to end.
// ----------------------------------------------------------------------------
module ray_supercover_rasterizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: begin_x, begin_y, end_x, end_y (lowest first)
   input  logic [rsr_pkg::REQ_BYTES*8-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: cell_x, cell_y (lowest first), zero padded
   output logic [rsr_pkg::RSP_BYTES*8-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // tuser: truncated
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [rsr_pkg::SCALE_BITS-1:0]     csr_wdata
);
   import rsr_pkg::*;

   cmd_type    cmd;
   status_type sts;

   rsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rsr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- hdl/rsr_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsr_ctrl
// Sequencer for divide, setup, multiply and cell walk of one ray.
// ----------------------------------------------------------------------------
module rsr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rsr_pkg::status_type sts,
   output rsr_pkg::cmd_type    cmd
);
   import rsr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_run = 1'b1;
            if (sts.div_done) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.vertical ? ST_VERT : ST_MUL;
         end
         ST_VERT: begin
            if (sts.can_emit) begin
               cmd.emit_v = 1'b1;
               if (sts.full || sts.cy_at_hi) state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            cmd.mul_run = 1'b1;
            if (sts.mul_done) state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.can_emit) begin
               cmd.emit_e = 1'b1;
               state_in   = sts.full ? ST_FIN : ST_INNER;
            end
         end
         ST_INNER: begin
            priority if (sts.acc_gt) begin
               if (sts.can_emit) begin
                  cmd.emit_i = 1'b1;
                  if (sts.full) state_in = ST_FIN;
               end
            end else if (sts.tail) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_EMIT;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hdl/rsr_dp.sv -----
// ----------------------------------------------------------------------------
// rsr_dp
// Divider lanes, shared multiplier, walk accumulator and cell output stage.
// ----------------------------------------------------------------------------
`include "ray_supercover_rasterizer_macros.svh"

module rsr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  rsr_pkg::cmd_type                  cmd,
   output rsr_pkg::status_type               sts,
   input  logic [rsr_pkg::REQ_BYTES*8-1:0]   req_tdata,
   input  logic                              csr_we,
   input  logic [rsr_pkg::SCALE_BITS-1:0]    csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rsr_pkg::RSP_BYTES*8-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser
);
   import rsr_pkg::*;

   localparam int C = COORD_BITS;
   localparam int S = SCALE_BITS;

   logic [S-1:0] scale_ff, s_ff;

   // divider lanes: 0 bx, 1 by, 2 ex, 3 ey, ends swapped if bx > ex; dvd shifts into quotient
   logic [C-1:0]            dvd_ff [4];
   logic [S-1:0]            rem_ff [4];
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;

   logic [C:0]   dy_ff;            // signed difference
   logic         up_ff;
   logic [C-1:0] ady;

   logic [C-1:0] cx_ff, cy_ff, hi_ff, end_ff;
   logic         tail_ff;

   logic [2:0]           mul_cnt_ff;
   logic [C-1:0]         dx_sub_ff;        // x span in subpixel units
   logic [C-1:0]         mul_a_sel;
   logic [MUL_B_BITS-1:0] mul_b;
   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS-1:0] den_ff, t1_ff, t2_ff, step_ff, t3_ff;
   logic signed [ACC_BITS-1:0] acc_ff, den_s, acc_in;

   logic [CNT_BITS-1:0] count_ff;
   logic                over_ff;
   logic [C-1:0]        pend_x_ff, pend_y_ff;
   logic                pend_vld_ff;
   logic [C-1:0]        out_x_ff, out_y_ff;
   logic                out_vld_ff, out_last_ff, out_trunc_ff;

   logic         emit, load_out;
   logic [C-1:0] emit_x, emit_y, cy_next, lo_q, hi_q;
   logic         out_free;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   // restoring divide, one quotient bit per cycle in each lane
   always_ff @(posedge clock) begin
      logic [S:0] r2;
      if (cmd.load) begin
         s_ff       <= (scale_ff == '0) ? S'(1) : scale_ff;
         div_cnt_ff <= '0;
         if (req_tdata[C-1:0] > req_tdata[3*C-1:2*C]) begin
            dvd_ff[0] <= req_tdata[3*C-1:2*C];
            dvd_ff[1] <= req_tdata[4*C-1:3*C];
            dvd_ff[2] <= req_tdata[C-1:0];
            dvd_ff[3] <= req_tdata[2*C-1:C];
            dy_ff <= {1'b0, req_tdata[2*C-1:C]} - {1'b0, req_tdata[4*C-1:3*C]};
         end else begin
            dvd_ff[0] <= req_tdata[C-1:0];
            dvd_ff[1] <= req_tdata[2*C-1:C];
            dvd_ff[2] <= req_tdata[3*C-1:2*C];
            dvd_ff[3] <= req_tdata[4*C-1:3*C];
            dy_ff <= {1'b0, req_tdata[4*C-1:3*C]} - {1'b0, req_tdata[2*C-1:C]};
         end
         for (int i = 0; i < 4; i++) rem_ff[i] <= '0;
      end else if (cmd.div_run) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         for (int i = 0; i < 4; i++) begin
            r2 = {rem_ff[i], dvd_ff[i][C-1]};
            if (r2 >= {1'b0, s_ff}) begin
               r2 = r2 - {1'b0, s_ff};
               dvd_ff[i] <= {dvd_ff[i][C-2:0], 1'b1};
            end else begin
               dvd_ff[i] <= {dvd_ff[i][C-2:0], 1'b0};
            end
            rem_ff[i] <= r2[S-1:0];
         end
      end
   end

   assign ady  = dy_ff[C] ? C'(-dy_ff) : dy_ff[C-1:0];
   assign lo_q = (dvd_ff[1] < dvd_ff[3]) ? dvd_ff[1] : dvd_ff[3];
   assign hi_q = (dvd_ff[1] < dvd_ff[3]) ? dvd_ff[3] : dvd_ff[1];

   // x span for the first two products
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_sub_ff <= (req_tdata[C-1:0] > req_tdata[3*C-1:2*C])
                      ? req_tdata[C-1:0] - req_tdata[3*C-1:2*C]
                      : req_tdata[3*C-1:2*C] - req_tdata[C-1:0];
      end
   end

   // shared multiplier, product registered into its slot
   always_comb begin
      unique case (mul_cnt_ff)
         MUL_DEN, MUL_STEP: mul_b = {s_ff, 1'b0};
         MUL_T1:   mul_b = {rem_ff[1], 1'b1};
         MUL_T2:   mul_b = {s_ff, 1'b0} - {rem_ff[0], 1'b0} - MUL_B_BITS'(1);
         MUL_T3:   mul_b = {rem_ff[2], 1'b1};
         default:  mul_b = '0;
      endcase
   end

   assign mul_a_sel = (mul_cnt_ff == MUL_DEN || mul_cnt_ff == MUL_T1) ? dx_sub_ff : ady;
   assign prod = PROD_BITS'(mul_a_sel) * PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         mul_cnt_ff <= MUL_DEN;
      end else if (cmd.mul_run) begin
         mul_cnt_ff <= mul_cnt_ff + 3'd1;
         unique case (mul_cnt_ff)
            MUL_DEN:  den_ff  <= prod;
            MUL_T1:   t1_ff   <= prod;
            MUL_T2:   t2_ff   <= prod;
            MUL_STEP: step_ff <= prod;
            MUL_T3:   t3_ff   <= prod;
            default:  ;
         endcase
      end
   end

   assign den_s = ACC_BITS'(den_ff);
   assign cy_next = up_ff ? cy_ff + 1'b1 : cy_ff - 1'b1;

   // walk registers
   always_comb begin
      acc_in = acc_ff;
      if (cmd.walk_init) begin
         acc_in = up_ff ? ACC_BITS'(t1_ff) + ACC_BITS'(t2_ff)
                        : den_s - ACC_BITS'(t1_ff) + ACC_BITS'(t2_ff);
      end else if (cmd.emit_i) begin
         acc_in = acc_ff - den_s;
      end else if (cmd.step) begin
         acc_in = acc_ff - ((acc_ff == den_s) ? den_s : '0)
                  + (((cx_ff + 1'b1) == end_ff) ? ACC_BITS'(t3_ff) : ACC_BITS'(step_ff));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.setup) begin
         cx_ff     <= dvd_ff[0];
         end_ff    <= dvd_ff[2];
         hi_ff     <= hi_q;
         up_ff     <= !dy_ff[C] && (dy_ff != '0);
         cy_ff     <= sts.vertical ? lo_q : dvd_ff[1];
         tail_ff   <= 1'b0;
      end else if (cmd.emit_v) begin
         cy_ff <= cy_ff + 1'b1;
      end else if (cmd.emit_i) begin
         cy_ff <= cy_next;
      end else if (cmd.step) begin
         cx_ff   <= cx_ff + 1'b1;
         tail_ff <= (cx_ff + 1'b1) == end_ff;
         if (acc_ff == den_s) cy_ff <= cy_next;
      end
   end

   // emission and pending-cell stage
   assign emit   = cmd.emit_v || cmd.emit_e || cmd.emit_i;
   assign emit_x = cx_ff;
   assign emit_y = cmd.emit_i ? cy_next : cy_ff;
   assign out_free = !out_vld_ff || rsp_tready;
   assign load_out = (emit && count_ff != CNT_BITS'(MAX_CELLS) && pend_vld_ff) || cmd.fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         over_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (load_out) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (cmd.load) begin
            count_ff <= '0;
            over_ff  <= 1'b0;
         end else if (emit) begin
            if (count_ff == CNT_BITS'(MAX_CELLS)) begin
               over_ff <= 1'b1;
            end else begin
               count_ff    <= count_ff + 1'b1;
               pend_vld_ff <= 1'b1;
            end
         end else if (cmd.fin) begin
            pend_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit && count_ff != CNT_BITS'(MAX_CELLS)) begin
         pend_x_ff <= emit_x;
         pend_y_ff <= emit_y;
         if (pend_vld_ff) begin
            out_x_ff     <= pend_x_ff;
            out_y_ff     <= pend_y_ff;
            out_last_ff  <= 1'b0;
            out_trunc_ff <= 1'b0;
         end
      end else if (cmd.fin) begin
         out_x_ff     <= pend_x_ff;
         out_y_ff     <= pend_y_ff;
         out_last_ff  <= 1'b1;
         out_trunc_ff <= over_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = (RSP_BYTES*8)'({out_y_ff, out_x_ff});
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

   assign sts.div_done = div_cnt_ff == DIV_CNT_BITS'(C - 1);
   assign sts.mul_done = mul_cnt_ff == MUL_T3;
   assign sts.vertical = dvd_ff[0] == dvd_ff[2];
   assign sts.cy_at_hi = cy_ff == hi_ff;
   assign sts.acc_gt   = acc_ff > den_s;
   assign sts.tail     = tail_ff;
   assign sts.full     = count_ff == CNT_BITS'(MAX_CELLS);
   assign sts.can_emit = !pend_vld_ff || out_free;
   assign sts.out_free = out_free;

   `RSR_CHECK(a_count_cap, count_ff <= CNT_BITS'(MAX_CELLS), "cell count above cap")
   `RSR_CHECK(a_over_full, !over_ff || count_ff == CNT_BITS'(MAX_CELLS), "overflow before cap")
   `RSR_CHECK_NEXT(a_fin_flush, cmd.fin, !pend_vld_ff && out_vld_ff && out_last_ff, "final cell not flushed")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: ray_supercover_rasterizer testbench
// Sends rays over the req stream and predicts every touched pixel with an
// in-bench midpoint walk. Each rsp transaction is checked against the oldest
// predicted cell, including tlast and the truncation flag. The scale register
// is stepped through its extremes between phases, with random idling on both
// stream sides.
// ----------------------------------------------------------------------------
module tb;
   import rsr_pkg::*;

   localparam int  COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int  IDLE_PCT    = 21;
   localparam int  CYCLE_LIMIT = 800000;
   localparam int  SETTLE      = 200;

   typedef struct {
      logic [COORD_BITS-1:0] cell_x;
      logic [COORD_BITS-1:0] cell_y;
      logic                  last;
      logic                  truncated;
   } cell_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_BYTES*8-1:0]      req_tdata = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_BYTES*8-1:0]      rsp_tdata;
   logic                        rsp_tlast;
   logic                        rsp_tuser;
   logic                        csr_we = 1'b0;
   logic [SCALE_BITS-1:0]       csr_wdata = '0;

   // predictor state
   logic [SCALE_BITS-1:0]       scale_shadow;
   cell_type                    pending_cells[$];
   longint                      walk_x[$];
   longint                      walk_y[$];
   bit                          walk_capped;

   bit                          calm = 1'b0;
   int                          fail_count = 0;
   int                          rays_sent = 0;
   int                          cells_checked = 0;
   int                          capped_rays = 0;
   int                          cycle_count = 0;

   ray_supercover_rasterizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Record a cell unless it repeats the previous one; a new distinct cell
   // past the cap marks the run as cut instead.
   function automatic void add_cell(longint x, longint y);
      if (walk_capped) return;
      if (walk_x.size() > 0 && walk_x[$] == x && walk_y[$] == y) return;
      if (walk_x.size() >= MAX_CELLS) begin
         walk_capped = 1'b1;
         return;
      end
      walk_x.insert(walk_x.size(), x);
      walk_y.insert(walk_y.size(), y);
   endfunction

   // Midpoint walk over pixels, x non-decreasing from (bx,by) to (ex,ey).
   function automatic void trace_ray(longint bx, longint by, longint ex, longint ey,
                                     longint s);
      longint cx, cy, dx, dy, den, acc, last_px, end_px, lo, hi;
      if (bx / s == ex / s) begin
         // one pixel column: straight vertical run
         lo = ((by < ey) ? by : ey) / s;
         hi = ((by < ey) ? ey : by) / s;
         for (cy = lo; cy <= hi && !walk_capped; cy++) add_cell(bx / s, cy);
         return;
      end
      dx = ex - bx;
      dy = ey - by;
      den = 2 * s * dx;
      cx = bx / s;
      cy = by / s;
      add_cell(cx, cy);
      acc = (2 * (by % s) + 1) * dx + dy * (2 * s - 2 * (bx % s) - 1);
      last_px = 2 * (ex % s) + 1;
      end_px = ex / s;
      if (dy > 0) begin
         forever begin
            add_cell(cx, cy);
            while (acc > den && !walk_capped) begin
               acc -= den;
               cy++;
               add_cell(cx, cy);
            end
            if (walk_capped) return;
            cx++;
            if (acc == den) begin
               acc -= den;
               cy++;
            end
            if (cx >= end_px) break;
            acc += dy * 2 * s;
         end
         acc += dy * last_px;
         add_cell(cx, cy);
         while (acc > den && !walk_capped) begin
            acc -= den;
            cy++;
            add_cell(cx, cy);
         end
      end else begin
         forever begin
            add_cell(cx, cy);
            while (acc < 0 && !walk_capped) begin
               acc += den;
               cy--;
               add_cell(cx, cy);
            end
            if (walk_capped) return;
            cx++;
            if (acc == 0) begin
               acc += den;
               cy--;
            end
            if (cx >= end_px) break;
            acc += dy * 2 * s;
         end
         acc += dy * last_px;
         add_cell(cx, cy);
         while (acc < 0 && !walk_capped) begin
            acc += den;
            cy--;
            add_cell(cx, cy);
         end
      end
   endfunction

   function automatic void predict_cells(longint bx, longint by, longint ex, longint ey);
      longint   s;
      cell_type c;
      s = (scale_shadow == 0) ? 1 : scale_shadow;
      walk_x.delete();
      walk_y.delete();
      walk_capped = 1'b0;
      if (bx > ex) trace_ray(ex, ey, bx, by, s);
      else         trace_ray(bx, by, ex, ey, s);
      foreach (walk_x[k]) begin
         c.cell_x    = walk_x[k][COORD_BITS-1:0];
         c.cell_y    = walk_y[k][COORD_BITS-1:0];
         c.last      = (k == walk_x.size() - 1);
         c.truncated = c.last && walk_capped;
         pending_cells.insert(pending_cells.size(), c);
      end
      if (walk_capped) capped_rays++;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // One ray per transaction; valid stays high across back-to-back rays and
   // is dropped only when an idle gap is taken.
   task automatic send_ray(int bx, int by, int ex, int ey);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 60);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ey[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                     by[COORD_BITS-1:0], bx[COORD_BITS-1:0]};
      do @(posedge clock); while (!req_tready);
      predict_cells(bx, by, ex, ey);
      rays_sent++;
   endtask

   // Let the block drain fully, then write the scale while idle.
   task automatic set_scale(int value);
      @(posedge clock);
      req_tvalid <= 1'b0;
      wait (pending_cells.size() == 0);
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[SCALE_BITS-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      scale_shadow = value[SCALE_BITS-1:0];
   endtask

   function automatic int clamp_coord(longint v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return int'(v);
   endfunction

   // Random ray of a random shape; short and column-bound shapes dominate so
   // the walk finishes often, long ones exercise the cap.
   task automatic random_ray();
      int s, bx, by, ex, ey, t, span;
      s = (scale_shadow == 0) ? 1 : scale_shadow;
      span = 6 * s;
      bx = $urandom_range(COORD_MAX);
      by = $urandom_range(COORD_MAX);
      case ($urandom_range(5))
         0, 1: begin   // short slanted
            ex = clamp_coord(longint'(bx) + $urandom_range(span));
            ey = clamp_coord(longint'(by) + $urandom_range(2 * span) - span);
         end
         2: begin      // same pixel column
            ex = clamp_coord(longint'(bx) - bx % s + $urandom_range(s - 1));
            ey = clamp_coord(longint'(by) + $urandom_range(2 * span) - span);
         end
         3: begin      // on pixel corners, hits the exact-tie steps
            bx = (bx / s) * s;
            by = (by / s) * s;
            ex = clamp_coord(longint'(bx) + s * $urandom_range(4));
            ey = clamp_coord(longint'(by) + longint'(s * (int'($urandom_range(8)) - 4)));
         end
         4: begin      // flat row
            ex = clamp_coord(longint'(bx) + $urandom_range(span));
            ey = by;
         end
         default: begin // anywhere, usually capped
            ex = $urandom_range(COORD_MAX);
            ey = $urandom_range(COORD_MAX);
         end
      endcase
      if ($urandom_range(1)) begin
         t = bx; bx = ex; ex = t;
         t = by; by = ey; ey = t;
      end
      send_ray(bx, by, ex, ey);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Directed rays at the reset scale: corners, both slopes, vertical,
   // single cell, cap reached.
   task automatic test_directed_rays();
      send_ray(0, 0, 0, 0);
      send_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_ray(0, 0, COORD_MAX, COORD_MAX);            // capped, ascending
      send_ray(COORD_MAX, 0, 0, COORD_MAX);            // swapped, descending
      send_ray(500, 100, 500, 9999);                   // vertical run
      send_ray(500, 9999, 999, 100);                   // vertical, reversed
      send_ray(0, 0, 3000, 3000);                      // corner ties
      send_ray(1500, 4500, 5500, 1500);                // descending
      send_ray(100, 200, 4100, 200);                   // flat row
      send_ray(999, 999, 1000, 1000);                  // diagonal corner step
      send_ray(10, 10, 10, 70000);                     // vertical capped
      send_ray(0, COORD_MAX, 300000, COORD_MAX - 7);
   endtask

   // Scale extremes: zero acts as one, the largest value 2047 used as given.
   task automatic test_scale_extremes();
      set_scale(0);
      send_ray(0, 0, 5, 3);
      send_ray(7, 2, 1, 9);
      set_scale(1);
      send_ray(3, 3, 3, 3);
      send_ray(20, 40, 60, 0);
      set_scale(2047);
      send_ray(0, 0, 2047 * 3, 2047 * 2);
      send_ray(COORD_MAX, COORD_MAX, COORD_MAX - 5000, 0);
      set_scale(1024);
      send_ray(1023, 1023, 1024, 1024);
      send_ray(0, 4096, 4096, 0);
   endtask

   task automatic test_random_rays();
      int scales[7] = '{1000, 1, 0, 2047, 1024, 7, 0};
      scales[6] = $urandom_range(2, 2046);
      foreach (scales[p]) begin
         set_scale(scales[p]);
         calm = (p == 3);   // one phase without any idling
         repeat (44) random_ray();
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result checking and sink backpressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cell_type c;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_cells.size() == 0) begin
               $error("unexpected cell (%0d,%0d)", rsp_tdata[COORD_BITS-1:0],
                      rsp_tdata[2*COORD_BITS-1:COORD_BITS]);
               fail_count++;
            end else begin
               c = pending_cells.pop_front();
               cells_checked++;
               if (rsp_tdata[COORD_BITS-1:0] !== c.cell_x) begin
                  $error("cell_x: expected %0d, got %0d", c.cell_x,
                         rsp_tdata[COORD_BITS-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== c.cell_y) begin
                  $error("cell_y: expected %0d, got %0d", c.cell_y,
                         rsp_tdata[2*COORD_BITS-1:COORD_BITS]);
                  fail_count++;
               end
               if (rsp_tlast !== c.last) begin
                  $error("last: expected %0d, got %0d", c.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== c.truncated) begin
                  $error("truncated: expected %0d, got %0d", c.truncated, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d cells outstanding", cycle_count,
                  pending_cells.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      scale_shadow = SCALE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_rays();
      test_scale_extremes();
      test_random_rays();
      @(posedge clock);
      req_tvalid <= 1'b0;
      wait (pending_cells.size() == 0);
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d rays over scales 0..2047, %0d cells checked, %0d runs cut at cap.",
               rays_sent, cells_checked, capped_rays);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rsr_pkg.sv
hdl/rsr_ctrl.sv
hdl/rsr_dp.sv
hdl/ray_supercover_rasterizer.sv
dv/tb.sv
